// ===== rtl/etu_pkg.sv =====
// ----------------------------------------------------------------------------
// etu_pkg: shared constants of the totient unit
// Word width, stream data width rounded up to whole bytes and divider step counter width.
// ----------------------------------------------------------------------------
package etu_pkg;

  localparam int WIDTH  = 32;
  localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(WIDTH);

endpackage

// ===== rtl/euler_totient_unit.sv =====
// ----------------------------------------------------------------------------
// euler_totient_unit: Euler totient by trial division
// Shared restoring divider driven by a small candidate sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per number; in_tdata holds the value.
//   out_* : one result per request; out_tdata holds phi(value).
//   The unit takes a request only while its sequencer is idle. It tries
//   2, 3, then 6k-1 / 6k+1 while p*p <= remainder. Every trial, every
//   repeated divide-out and every result update runs through a single
//   restoring divider, one quotient bit per cycle, and each division ends
//   in an evaluate state. The unit handles one request at a time; the next
//   request is taken as soon as the finished result moves to the output
//   register. Reset clears the sequencer and the output valid flag.
//   A stalled receiver holds out_tdata; the unit finishes the current
//   request and waits with it until the output register frees up.
// ----------------------------------------------------------------------------
module euler_totient_unit
  import etu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [WIDTH-1:0] value
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata   // [WIDTH-1:0] totient
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_TEST   = 2'd0,   // n / p: divisibility and bound check
    OP_REDUCE = 2'd1,   // res / p after p divided out
    OP_FINAL  = 2'd2    // res / leftover prime
  } op_t;

  localparam logic [WIDTH-1:0] P_TWO   = WIDTH'(2);
  localparam logic [WIDTH-1:0] P_THREE = WIDTH'(3);
  localparam logic [WIDTH-1:0] P_FIVE  = WIDTH'(5);
  localparam logic [WIDTH-1:0] P_STEP  = WIDTH'(6);
  localparam logic [WIDTH-1:0] ONE     = WIDTH'(1);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [WIDTH-1:0]    n_r, n_nxt;
  logic [WIDTH-1:0]    res_r, res_nxt;
  logic [WIDTH-1:0]    p_r, p_nxt;
  logic                chk_r, chk_nxt;
  logic                hi_r, hi_nxt;
  logic                found_r, found_nxt;
  logic [WIDTH-1:0]    dvd_r, dvd_nxt;
  logic [WIDTH-1:0]    den_r, den_nxt;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [WIDTH-1:0]    out_data_r, out_data_nxt;

  logic [WIDTH:0]      trial;
  logic [WIDTH:0]      diff;
  logic                ge;
  logic [WIDTH-1:0]    cand_p;
  logic                cand_chk;
  logic                cand_hi;
  logic                start;
  logic [WIDTH-1:0]    s_dvd;
  logic [WIDTH-1:0]    s_den;
  op_t                 s_op;

  // one restoring step of the shared divider
  assign trial = {rem_r, dvd_r[WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = ~diff[WIDTH];

  // candidate order: 2, 3, 5, 7, 11, 13, ...; bound checked on each 6k-1
  always_comb begin
    if (p_r == P_TWO) begin
      cand_p   = P_THREE;
      cand_chk = 1'b0;
      cand_hi  = 1'b0;
    end else if (p_r == P_THREE) begin
      cand_p   = P_FIVE;
      cand_chk = 1'b1;
      cand_hi  = 1'b0;
    end else if (!hi_r) begin
      cand_p   = p_r + P_TWO;
      cand_chk = 1'b0;
      cand_hi  = 1'b1;
    end else begin
      cand_p   = p_r + (P_STEP - P_TWO);
      cand_chk = 1'b1;
      cand_hi  = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    n_nxt          = n_r;
    res_nxt        = res_r;
    p_nxt          = p_r;
    chk_nxt        = chk_r;
    hi_nxt         = hi_r;
    found_nxt      = found_r;
    dvd_nxt        = dvd_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    start          = 1'b0;
    s_dvd          = n_r;
    s_den          = p_r;
    s_op           = OP_TEST;

    if (out_tvalid_r && out_tready)
      out_tvalid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[WIDTH-1:0] == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            n_nxt     = in_tdata[WIDTH-1:0];
            res_nxt   = in_tdata[WIDTH-1:0];
            p_nxt     = P_TWO;
            chk_nxt   = 1'b0;
            hi_nxt    = 1'b0;
            found_nxt = 1'b0;
            start     = 1'b1;
            s_dvd     = in_tdata[WIDTH-1:0];
            s_den     = P_TWO;
            s_op      = OP_TEST;
          end
        end
      end
      S_DIV: begin
        rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        dvd_nxt = {dvd_r[WIDTH-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH - 1))
          state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // dvd_r holds the quotient, rem_r the remainder
        unique case (op_r)
          OP_TEST: begin
            if (chk_r && (p_r > dvd_r)) begin
              if (n_r > ONE) begin
                start = 1'b1;
                s_dvd = res_r;
                s_den = n_r;
                s_op  = OP_FINAL;
              end else begin
                state_nxt = S_DONE;
              end
            end else if (rem_r == '0) begin
              n_nxt     = dvd_r;
              found_nxt = 1'b1;
              chk_nxt   = 1'b0;
              start     = 1'b1;
              s_dvd     = dvd_r;
              s_den     = p_r;
              s_op      = OP_TEST;
            end else if (found_r) begin
              start = 1'b1;
              s_dvd = res_r;
              s_den = p_r;
              s_op  = OP_REDUCE;
            end else begin
              p_nxt     = cand_p;
              chk_nxt   = cand_chk;
              hi_nxt    = cand_hi;
              found_nxt = 1'b0;
              start     = 1'b1;
              s_dvd     = n_r;
              s_den     = cand_p;
              s_op      = OP_TEST;
            end
          end
          OP_REDUCE: begin
            res_nxt   = res_r - dvd_r;
            p_nxt     = cand_p;
            chk_nxt   = cand_chk;
            hi_nxt    = cand_hi;
            found_nxt = 1'b0;
            start     = 1'b1;
            s_dvd     = n_r;
            s_den     = cand_p;
            s_op      = OP_TEST;
          end
          OP_FINAL: begin
            res_nxt   = res_r - dvd_r;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (start) begin
      dvd_nxt   = s_dvd;
      den_nxt   = s_den;
      op_nxt    = s_op;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    p_r        <= p_nxt;
    chk_r      <= chk_nxt;
    hi_r       <= hi_nxt;
    found_r    <= found_nxt;
    dvd_r      <= dvd_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(out_data_r);

endmodule

// ===== rtl/etu_checker.sv =====
// ----------------------------------------------------------------------------
// etu_checker: port-level checks of the totient unit
// Reset behavior, busy window after a request, output hold under stall.
// ----------------------------------------------------------------------------
module etu_checker
  import etu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [DATA_W-1:0] in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a taken request drops in_tready in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after a request");

  // a request with value zero, taken while no result waits, is answered with zero via the done state
  a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[WIDTH-1:0] == '0) && !out_tvalid)
    |=> ##1 (out_tvalid && (out_tdata == '0)))
    else $error("zero input not answered with zero");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind euler_totient_unit etu_checker u_etu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/euler_totient_unit_tb.sv =====
// ----------------------------------------------------------------------------
// euler_totient_unit_tb: self-checking bench for the totient unit
// Sends corner values and then random numbers through the request stream,
// predicts phi(value) for every accepted request and checks each result in
// order. The request side idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module euler_totient_unit_tb;
  import etu_pkg::*;

  localparam int CYCLE_LIMIT  = 40_000_000;
  localparam int RANDOM_ITEMS = 74;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] totient;
  } totient_entry_t;

  class totient_scoreboard;
    totient_entry_t expected_q[$];
    int             mismatches;

    function new();
      mismatches = 0;
    endfunction

    // trial division over 2, 3, then 6k-1 / 6k+1
    function automatic logic [WIDTH-1:0] totient_of(logic [WIDTH-1:0] value);
      longint unsigned rem;
      longint unsigned acc;
      longint unsigned p;
      rem = value;
      if (rem == 0) return '0;
      acc = rem;
      p   = 2;
      while (p <= rem / p) begin
        if (rem % p == 0) begin
          while (rem % p == 0) rem = rem / p;
          acc = acc - acc / p;
        end
        if (p == 2) p = 3;
        else if (p == 3) p = 5;
        else if (p % 6 == 5) p = p + 2;
        else p = p + 4;
      end
      // whatever is left above 1 is a prime
      if (rem > 1) acc = acc - acc / rem;
      return acc[WIDTH-1:0];
    endfunction

    function void note_request(logic [WIDTH-1:0] value);
      totient_entry_t e;
      e.value   = value;
      e.totient = totient_of(value);
      expected_q.insert(expected_q.size(), e);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [DATA_W-1:0] got);
      totient_entry_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with no request pending", got));
      end else begin
        e = expected_q.pop_front();
        if (got !== DATA_W'(e.totient))
          report_mismatch($sformatf("totient of %0d: got %0d, want %0d",
                                    e.value, got, e.totient));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;    // [WIDTH-1:0] value
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;   // [WIDTH-1:0] totient

  totient_scoreboard sb = new();
  int  cycle_count = 0;
  bit  in_quiet    = 0;
  bit  out_quiet   = 0;

  euler_totient_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_idle(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // mostly small numbers of 1 to 20 bits, else random words shifted up by 8 bits
  function automatic logic [WIDTH-1:0] pick_value();
    int w;
    if ($urandom_range(0, 99) < 85) begin
      w = $urandom_range(1, 20);
      return WIDTH'($urandom) & ((WIDTH'(1) << w) - 1);
    end
    return WIDTH'($urandom) << 8;
  endfunction

  task automatic send_request(logic [WIDTH-1:0] value);
    int gap;
    gap = pick_idle(in_quiet);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = DATA_W'(value);
    do @(posedge clk); while (!in_tready);
    sb.note_request(value);
  endtask

  // receiver stalls
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (out_quiet) begin
        out_tready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready = 1'b1;
        end else begin
          out_tready = 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(30, 300);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      if ($urandom_range(0, 7) == 0) out_quiet = !out_quiet;
    end
  end

  initial begin
    longint unsigned corner_values[$];
    int i;
    // squares of primes sit right on the p*p <= remainder bound;
    // 35 and 5005 are products of distinct primes 5, 7 (and 11, 13)
    corner_values = '{0, 1, 2, 3, 4, 7, 8, 12, 25, 35, 49, 121, 5005, 30030,
                      65536, 65537, 999983, 1000000, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h8000_0000, 32'd3486784401,
                      32'd4294836225, 32'd4294967292, 32'hFFFF_FFFF,
                      32'd4294967291};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_values[i]) send_request(WIDTH'(corner_values[i]));

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
      send_request(pick_value());
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/etu_pkg.sv
rtl/euler_totient_unit.sv
rtl/etu_checker.sv
dv/euler_totient_unit_tb.sv
